// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the varint frame deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define VFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/vfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Varint frame deframer package
// Shared types and constants for the deframer modules.
// ----------------------------------------------------------------------------
package vfd_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_MAX_PAYLOAD = '0;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

  localparam logic [7:0] PREAMBLE_PLAIN = 8'h00;
  localparam logic [7:0] PREAMBLE_CRYPT = 8'h01;
  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
  localparam logic [6:0] VARINT_SHIFT_LIM = 7'd64;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_LEN  = 2'd1,
    PH_TYPE = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_HDR_BYTE = 3'd0,
    EV_HDR_DONE = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_MARKER   = 3'd3,
    EV_ERROR    = 3'd4
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [31:0] msg_kind;
    logic [15:0] body_len;
    logic [7:0]  data_byte;
    logic        frame_last;
  } res_t;

endpackage

// ===== design/vfd_in_if.sv =====
// ----------------------------------------------------------------------------
// Byte stream channel
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
interface vfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== design/vfd_out_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries one parse event per item.
// ----------------------------------------------------------------------------
interface vfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] msg_kind;
  logic [15:0] body_len;
  logic [7:0]  data_byte;
  logic        frame_last;

  modport source (output valid, output event_res, output msg_kind, output body_len,
                  output data_byte, output frame_last, input ready);
  modport sink (input valid, input event_res, input msg_kind, input body_len,
                input data_byte, input frame_last, output ready);
endinterface

// ===== design/vfd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Deframer configuration registers
// APB-style register port holding the maximum payload length.
// ----------------------------------------------------------------------------
module vfd_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [vfd_pkg::DATA_W-1:0]  pwdata,
  output logic [vfd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [15:0]                 max_payload
);

  logic                       hit;

  assign pready = 1'b1;
  assign hit    = (paddr[vfd_pkg::ADDR_W-1:2] == vfd_pkg::REG_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= vfd_pkg::MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_payload <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(vfd_pkg::DATA_W-16){1'b0}}, max_payload};
    end
  end

endmodule

// ===== design/vfd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Frame state machine and varint assembly, one byte per advance.
// ----------------------------------------------------------------------------
module vfd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [7:0]         in_byte,
  input  logic [15:0]        max_payload,
  output vfd_pkg::res_t      res
);

  vfd_pkg::phase_t phase, phase_next;
  logic [31:0] acc, acc_next;
  logic        acc_hi, acc_hi_next;
  logic [3:0]  cnt, cnt_next;
  logic [15:0] len16, len16_next;
  logic        len_big, len_big_next;
  logic [15:0] left, left_next;
  logic [31:0] ftype, ftype_next;

  logic [6:0]  sh;
  logic [63:0] contrib;
  logic [31:0] acc_or;
  logic        hi_or;
  logic        more;
  logic        overlong;
  logic        too_long;

  assign sh       = 7'({cnt, 3'b000}) - 7'(cnt);
  assign contrib  = (sh < vfd_pkg::VARINT_SHIFT_LIM) ? (64'(in_byte[6:0]) << sh[5:0]) : '0;
  assign acc_or   = acc | contrib[31:0];
  assign hi_or    = acc_hi | (|contrib[63:16]);
  assign more     = in_byte[7];
  assign overlong = more && (cnt == vfd_pkg::VARINT_LAST_IDX);
  assign too_long = len_big || (len16 > max_payload);

  always_comb begin
    phase_next   = phase;
    acc_next     = acc;
    acc_hi_next  = acc_hi;
    cnt_next     = cnt;
    len16_next   = len16;
    len_big_next = len_big;
    left_next    = left;
    ftype_next   = ftype;
    case (phase)
      vfd_pkg::PH_WAIT: begin
        if (in_byte == vfd_pkg::PREAMBLE_PLAIN) begin
          phase_next  = vfd_pkg::PH_LEN;
          acc_next    = '0;
          acc_hi_next = 1'b0;
          cnt_next    = '0;
        end
      end
      vfd_pkg::PH_LEN: begin
        acc_next    = acc_or;
        acc_hi_next = hi_or;
        if (overlong) begin
          phase_next = vfd_pkg::PH_WAIT;
        end else if (!more) begin
          len16_next   = acc_or[15:0];
          len_big_next = hi_or;
          acc_next     = '0;
          acc_hi_next  = 1'b0;
          cnt_next     = '0;
          phase_next   = vfd_pkg::PH_TYPE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      vfd_pkg::PH_TYPE: begin
        acc_next    = acc_or;
        acc_hi_next = hi_or;
        if (overlong || (!more && too_long)) begin
          phase_next = vfd_pkg::PH_WAIT;
        end else if (more) begin
          cnt_next = cnt + 4'd1;
        end else begin
          ftype_next = acc_or;
          left_next  = len16;
          phase_next = (len16 == '0) ? vfd_pkg::PH_WAIT : vfd_pkg::PH_DATA;
        end
      end
      vfd_pkg::PH_DATA: begin
        left_next = left - 16'd1;
        if (left == 16'd1) begin
          phase_next = vfd_pkg::PH_WAIT;
        end
      end
      default: begin
        phase_next = vfd_pkg::PH_WAIT;
      end
    endcase
  end

  always_comb begin
    res = '0;
    res.event_res = vfd_pkg::EV_HDR_BYTE;
    case (phase)
      vfd_pkg::PH_WAIT: begin
        if (in_byte == vfd_pkg::PREAMBLE_CRYPT) begin
          res.event_res = vfd_pkg::EV_MARKER;
        end else if (in_byte != vfd_pkg::PREAMBLE_PLAIN) begin
          res.event_res = vfd_pkg::EV_ERROR;
        end
      end
      vfd_pkg::PH_LEN: begin
        if (overlong) begin
          res.event_res = vfd_pkg::EV_ERROR;
        end
      end
      vfd_pkg::PH_TYPE: begin
        if (overlong || (!more && too_long)) begin
          res.event_res = vfd_pkg::EV_ERROR;
        end else if (!more) begin
          res.event_res  = vfd_pkg::EV_HDR_DONE;
          res.msg_kind   = acc_or;
          res.body_len   = len16;
          res.frame_last = (len16 == '0);
        end
      end
      vfd_pkg::PH_DATA: begin
        res.event_res  = vfd_pkg::EV_PAYLOAD;
        res.msg_kind   = ftype;
        res.body_len   = len16;
        res.data_byte  = in_byte;
        res.frame_last = (left == 16'd1);
      end
      default: begin
        res.event_res = vfd_pkg::EV_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= vfd_pkg::PH_WAIT;
      acc     <= '0;
      acc_hi  <= 1'b0;
      cnt     <= '0;
      len16   <= '0;
      len_big <= 1'b0;
      left    <= '0;
      ftype   <= '0;
    end else if (adv) begin
      phase   <= phase_next;
      acc     <= acc_next;
      acc_hi  <= acc_hi_next;
      cnt     <= cnt_next;
      len16   <= len16_next;
      len_big <= len_big_next;
      left    <= left_next;
      ftype   <= ftype_next;
    end
  end

endmodule

// ===== design/varint_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Varint frame deframer
// Splits a received byte stream into frames and reports one event per byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle unless the result side stalls,
// and returns exactly one event for each byte, in order. A byte passes
// through an input register and the frame parser into a result register,
// from which its event is presented. Both registers advance whenever the
// result register is empty or its item is being taken, so the stream runs
// at one item per cycle unless the result side stalls. The maximum payload
// length should be written only while no items are in flight.
`include "assert_macros.svh"

module varint_frame_deframer_top (
  input  logic                        clk,
  input  logic                        rst,
  vfd_in_if.sink                      stream,
  vfd_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [vfd_pkg::DATA_W-1:0]  pwdata,
  output logic [vfd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic          stage_valid;
  logic [7:0]    stage_byte;
  logic          out_valid;
  vfd_pkg::res_t out_res;
  vfd_pkg::res_t res;
  logic [15:0]   max_payload;
  logic          out_take;
  logic          move;

  vfd_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  vfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .adv         (move),
    .in_byte     (stage_byte),
    .max_payload (max_payload),
    .res         (res)
  );

  assign out_take     = !out_valid || result.ready;
  assign move         = stage_valid && out_take;
  assign stream.ready = !stage_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stream.ready) begin
      stage_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      stage_byte <= stream.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.event_res  = out_res.event_res;
  assign result.msg_kind   = out_res.msg_kind;
  assign result.body_len   = out_res.body_len;
  assign result.data_byte  = out_res.data_byte;
  assign result.frame_last = out_res.frame_last;

  `VFD_ASSERT_NXT(a_move_fills, clk, rst, move, out_valid, "Parsed item did not reach result")
  `VFD_ASSERT_IMP(a_err_zero, clk, rst, out_valid && (out_res.event_res == vfd_pkg::EV_ERROR), (out_res.msg_kind == '0) && (out_res.body_len == '0) && (out_res.data_byte == '0) && !out_res.frame_last, "Error item carries data")
  `VFD_ASSERT_IMP(a_last_kind, clk, rst, out_valid && out_res.frame_last, (out_res.event_res == vfd_pkg::EV_HDR_DONE) || (out_res.event_res == vfd_pkg::EV_PAYLOAD), "Frame end on wrong event")
  `VFD_ASSERT_IMP(a_body_len, clk, rst, out_valid && (out_res.event_res == vfd_pkg::EV_PAYLOAD), out_res.body_len != '0, "Payload byte in empty frame")

endmodule
